### design/serial_bank_switch_mapper_defines.svh
// assertion macros for the serial bank switch mapper checker
`ifndef SERIAL_BANK_SWITCH_MAPPER_DEFINES_SVH
`define SERIAL_BANK_SWITCH_MAPPER_DEFINES_SVH

// same-cycle implication, sampled on i_clk and disabled in reset
`define SBSM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbsm check failed");

// next-cycle implication, sampled on i_clk and disabled in reset
`define SBSM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbsm check failed");

`endif

### design/sbsm_pkg.sv
// types, constants and helpers shared by the serial bank switch mapper
`default_nettype none

package sbsm_pkg;

    localparam int CART_RAM_DEPTH = 8192;
    localparam int RAM_AW         = $clog2(CART_RAM_DEPTH);

    localparam logic [4:0] PRG_COUNT_RESET = 5'd16;
    localparam logic [4:0] CHR_COUNT_RESET = 5'd0;
    localparam logic [4:0] CTRL_RESET      = 5'h1C;
    localparam logic [4:0] CTRL_PRG_FORCE  = 5'h0C;
    localparam logic [4:0] CHR_FULL_MASK   = 5'h1E;
    localparam logic [2:0] LOAD_LAST       = 3'd5;

    typedef enum logic [1:0] {
        REQ_CPU_RD = 2'd0,
        REQ_CPU_WR = 2'd1,
        REQ_PPU_RD = 2'd2,
        REQ_PPU_WR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG      = 2'd3
    } t_reg_sel;

    typedef enum logic [1:0] {
        PRG_MODE_32K_A   = 2'd0,
        PRG_MODE_32K_B   = 2'd1,
        PRG_MODE_FIX_LOW = 2'd2,
        PRG_MODE_FIX_TOP = 2'd3
    } t_prg_mode;

    typedef enum logic [0:0] {
        CFG_PRG_COUNT = 1'b0,
        CFG_CHR_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0] control;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic [4:0] chr_full;
        logic [2:0] prg_full;
        logic [3:0] prg_low;
        logic [3:0] prg_high;
        logic [1:0] mirror;
    } t_banks;

    // ram byte index: 13-bit window offset folded into the ram depth
    function automatic logic [RAM_AW-1:0] ram_index(input logic [12:0] a);
        logic [16:0] v;
        v = 17'(a);
        for (int i = 0; i < 3; i++) begin
            if (v >= 17'(CART_RAM_DEPTH)) begin
                v = v - 17'(CART_RAM_DEPTH);
            end
        end
        return RAM_AW'(v);
    endfunction

endpackage

`default_nettype wire

### design/sbsm_if.sv
// beat channels of the serial bank switch mapper
`default_nettype none

interface sbsm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source(output valid, output req_type, output address, output write_data,
                   input ready);
    modport sink(input valid, input req_type, input address, input write_data,
                 output ready);
endinterface

interface sbsm_out_if;
    logic        valid;
    logic        ready;
    logic        handled;
    logic [17:0] mapped_address;
    logic        to_cart_ram;
    logic [7:0]  read_data;
    logic [1:0]  mirror_mode;

    modport source(output valid, output handled, output mapped_address,
                   output to_cart_ram, output read_data, output mirror_mode,
                   input ready);
    modport sink(input valid, input handled, input mapped_address,
                 input to_cart_ram, input read_data, input mirror_mode,
                 output ready);
endinterface

`default_nettype wire

### design/serial_bank_switch_mapper.sv
// Serial bank switch cartridge mapper. One bus access (cpu or ppu, read or write) is taken
// per clock on i_in when ready and gives one registered result beat on o_out; one further
// beat is buffered while the output waits. The single-port cartridge ram sets the pace,
// serving one read or one write per cycle, and needs no clearing pass: bytes never written
// read back as whatever the ram holds. Write the bank counts over the apb port at byte
// addresses 0 and 4 while no access is in flight; the block does not enforce it.
`default_nettype none

module serial_bank_switch_mapper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sbsm_in_if.sink          i_in,
    sbsm_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [4:0] r_prg_count;
    logic [4:0] r_chr_count;

    logic                       in_acc;
    logic                       a_move;
    logic                       o_take;
    logic                       cfg_wr;
    logic                       is_ram_win;
    logic                       load;
    logic                       ram_we;
    logic                       ram_re;
    logic [sbsm_pkg::RAM_AW-1:0] ram_idx;
    logic                       n_handled;
    logic [17:0]                n_mapped;
    logic                       n_ram;
    logic [4:0]                 chr_bank;
    logic [3:0]                 prg_bank;
    sbsm_pkg::t_banks           banks;
    logic [1:0]                 mirror_next;

    logic [7:0] mem [sbsm_pkg::CART_RAM_DEPTH];
    logic [7:0] r_ram_q;

    logic        r_a_valid;
    logic        r_a_handled;
    logic [17:0] r_a_mapped;
    logic        r_a_ram;
    logic        r_a_rd;
    logic [1:0]  r_a_mirror;

    logic        r_o_valid;
    logic        r_o_handled;
    logic [17:0] r_o_mapped;
    logic        r_o_ram;
    logic [7:0]  r_o_rdata;
    logic [1:0]  r_o_mirror;

    // configuration port
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (sbsm_pkg::t_cfg_idx'(paddr[2]) == sbsm_pkg::CFG_CHR_COUNT)
                  ? 32'(r_chr_count) : 32'(r_prg_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count <= sbsm_pkg::PRG_COUNT_RESET;
            r_chr_count <= sbsm_pkg::CHR_COUNT_RESET;
        end else if (cfg_wr) begin
            if (sbsm_pkg::t_cfg_idx'(paddr[2]) == sbsm_pkg::CFG_CHR_COUNT) begin
                r_chr_count <= pwdata[4:0];
            end else begin
                r_prg_count <= pwdata[4:0];
            end
        end
    end

    // handshake
    assign o_take      = r_o_valid & o_out.ready;
    assign a_move      = r_a_valid & (~r_o_valid | o_out.ready);
    assign i_in.ready  = ~r_a_valid | a_move;
    assign in_acc      = i_in.valid & i_in.ready;

    // access decode
    assign is_ram_win = (i_in.address[15:13] == 3'b011);
    assign load   = in_acc & (i_in.req_type == sbsm_pkg::REQ_CPU_WR) & i_in.address[15];
    assign ram_we = in_acc & (i_in.req_type == sbsm_pkg::REQ_CPU_WR) & is_ram_win;
    assign ram_re = in_acc & (i_in.req_type == sbsm_pkg::REQ_CPU_RD) & is_ram_win;
    assign ram_idx = sbsm_pkg::ram_index(i_in.address[12:0]);

    sbsm_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (load),
        .i_sel            (sbsm_pkg::t_reg_sel'(i_in.address[14:13])),
        .i_data           (i_in.write_data),
        .i_prg_bank_count (r_prg_count),
        .o_banks          (banks),
        .o_mirror_next    (mirror_next)
    );

    always_comb begin
        n_handled = 1'b0;
        n_mapped  = '0;
        n_ram     = 1'b0;
        prg_bank  = i_in.address[14] ? banks.prg_high : banks.prg_low;
        chr_bank  = i_in.address[12] ? banks.chr_high : banks.chr_low;
        case (sbsm_pkg::t_req'(i_in.req_type))
            sbsm_pkg::REQ_CPU_RD: begin
                if (is_ram_win) begin
                    n_handled = 1'b1;
                    n_ram     = 1'b1;
                end else if (i_in.address[15]) begin
                    n_handled = 1'b1;
                    if (banks.control[3]) begin
                        n_mapped = {prg_bank, i_in.address[13:0]};
                    end else begin
                        n_mapped = {banks.prg_full, i_in.address[14:0]};
                    end
                end
            end
            sbsm_pkg::REQ_CPU_WR: begin
                if (is_ram_win) begin
                    n_handled = 1'b1;
                    n_ram     = 1'b1;
                end
            end
            sbsm_pkg::REQ_PPU_RD: begin
                if (i_in.address[15:13] == 3'b000) begin
                    n_handled = 1'b1;
                    if (r_chr_count == 5'd0) begin
                        n_mapped = 18'(i_in.address[12:0]);
                    end else if (banks.control[4]) begin
                        n_mapped = {1'b0, chr_bank, i_in.address[11:0]};
                    end else begin
                        n_mapped = (18'(banks.chr_full) << 12) + 18'(i_in.address[12:0]);
                    end
                end
            end
            default: begin
                if (i_in.address[15:13] == 3'b000) begin
                    n_handled = 1'b1;
                    if (r_chr_count == 5'd0) begin
                        n_mapped = 18'(i_in.address[12:0]);
                    end
                end
            end
        endcase
    end

    // cartridge ram
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            mem[ram_idx] <= i_in.write_data;
        end
        if (ram_re) begin
            r_ram_q <= mem[ram_idx];
        end
    end

    // ram stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
        if (in_acc) begin
            r_a_handled <= n_handled;
            r_a_mapped  <= n_mapped;
            r_a_ram     <= n_ram;
            r_a_rd      <= ram_re;
            r_a_mirror  <= mirror_next;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_move) begin
            r_o_valid <= 1'b1;
        end else if (o_take) begin
            r_o_valid <= 1'b0;
        end
        if (a_move) begin
            r_o_handled <= r_a_handled;
            r_o_mapped  <= r_a_mapped;
            r_o_ram     <= r_a_ram;
            r_o_rdata   <= r_a_rd ? r_ram_q : 8'd0;
            r_o_mirror  <= r_a_mirror;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.handled        = r_o_handled;
    assign o_out.mapped_address = r_o_mapped;
    assign o_out.to_cart_ram    = r_o_ram;
    assign o_out.read_data      = r_o_rdata;
    assign o_out.mirror_mode    = r_o_mirror;

endmodule

`default_nettype wire

### design/sbsm_regs.sv
// serial load register and bank registers
`default_nettype none

module sbsm_regs (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire sbsm_pkg::t_reg_sel    i_sel,
    input  wire logic [7:0]            i_data,
    input  wire logic [4:0]            i_prg_bank_count,
    output sbsm_pkg::t_banks           o_banks,
    output logic [1:0]                 o_mirror_next
);

    logic [4:0]       r_shift;
    logic [2:0]       r_count;
    sbsm_pkg::t_banks r_banks;

    logic [4:0]       n_shift;
    logic [2:0]       n_count;
    sbsm_pkg::t_banks n_banks;
    logic [4:0]       v;
    logic [2:0]       cnt_inc;
    logic [3:0]       prg_top;

    always_comb begin
        n_shift = r_shift;
        n_count = r_count;
        n_banks = r_banks;
        v       = {i_data[0], r_shift[4:1]};
        cnt_inc = r_count + 3'd1;
        prg_top = 4'(i_prg_bank_count - 5'd1);
        if (i_load) begin
            if (i_data[7]) begin
                n_shift         = '0;
                n_count         = '0;
                n_banks.control = r_banks.control | sbsm_pkg::CTRL_PRG_FORCE;
            end else if (cnt_inc != sbsm_pkg::LOAD_LAST) begin
                n_shift = v;
                n_count = cnt_inc;
            end else begin
                n_shift = '0;
                n_count = '0;
                case (i_sel)
                    sbsm_pkg::SEL_CONTROL: begin
                        n_banks.control = v;
                        n_banks.mirror  = v[1:0];
                    end
                    sbsm_pkg::SEL_CHR_LOW: begin
                        if (r_banks.control[4]) begin
                            n_banks.chr_low = v;
                        end else begin
                            n_banks.chr_full = v & sbsm_pkg::CHR_FULL_MASK;
                        end
                    end
                    sbsm_pkg::SEL_CHR_HIGH: begin
                        if (r_banks.control[4]) begin
                            n_banks.chr_high = v;
                        end
                    end
                    default: begin
                        case (sbsm_pkg::t_prg_mode'(r_banks.control[3:2]))
                            sbsm_pkg::PRG_MODE_FIX_LOW: begin
                                n_banks.prg_low  = '0;
                                n_banks.prg_high = v[3:0];
                            end
                            sbsm_pkg::PRG_MODE_FIX_TOP: begin
                                n_banks.prg_low  = v[3:0];
                                n_banks.prg_high = prg_top;
                            end
                            default: begin
                                n_banks.prg_full = v[3:1];
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift          <= '0;
            r_count          <= '0;
            r_banks.control  <= sbsm_pkg::CTRL_RESET;
            r_banks.chr_low  <= '0;
            r_banks.chr_high <= '0;
            r_banks.chr_full <= '0;
            r_banks.prg_full <= '0;
            r_banks.prg_low  <= '0;
            r_banks.prg_high <= 4'(sbsm_pkg::PRG_COUNT_RESET - 5'd1);
            r_banks.mirror   <= '0;
        end else begin
            r_shift <= n_shift;
            r_count <= n_count;
            r_banks <= n_banks;
        end
    end

    assign o_banks       = r_banks;
    assign o_mirror_next = n_banks.mirror;

endmodule

`default_nettype wire

### design/sbsm_checker.sv
// port checks for the serial bank switch mapper, bound to the top level
`default_nettype none

`include "serial_bank_switch_mapper_defines.svh"

module sbsm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_out_handled,
    input wire logic [17:0] i_out_mapped,
    input wire logic        i_out_ram,
    input wire logic [7:0]  i_out_rdata
);

    logic in_acc;
    assign in_acc = i_in_valid & i_in_ready;

    // stalled beat holds
    `SBSM_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_mapped) && $stable(i_out_rdata))

    // a fresh result beat needs an access accepted into the ram stage before it
    `SBSM_ASSERT_IMP(a_no_phantom, $rose(i_out_valid), $past(in_acc, 2))

    // input side never blocked while the output is empty
    `SBSM_ASSERT_IMP(a_ready_when_empty, !i_out_valid, i_in_ready)

    // unclaimed or ram beats carry no rom offset
    `SBSM_ASSERT_IMP(a_quiet_fields, i_out_valid && (!i_out_handled || i_out_ram), i_out_mapped == 18'd0 && (i_out_handled || (!i_out_ram && i_out_rdata == 8'd0)))

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_handled (o_out.handled),
    .i_out_mapped  (o_out.mapped_address),
    .i_out_ram     (o_out.to_cart_ram),
    .i_out_rdata   (o_out.read_data)
);

`default_nettype wire
